### rtl/sba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slab block allocator package
// Shared sizes, list codes and result status codes.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int NUM_SLABS  = 16;
    localparam int BLOCKS_MAX = 64;

    localparam int SLAB_W  = $clog2(NUM_SLABS);
    localparam int INDEX_W = $clog2(BLOCKS_MAX);
    localparam int SREF_W  = SLAB_W + 1;
    localparam int LINK_W  = INDEX_W + 1;
    localparam int ADDR_W  = SLAB_W + INDEX_W;
    localparam int DEPTH   = NUM_SLABS * BLOCKS_MAX;

    localparam logic [SREF_W-1:0] SLAB_NONE = SREF_W'(NUM_SLABS);
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(BLOCKS_MAX);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLAB   = 2'd1,
        ST_IDLE_FREE = 2'd2
    } t_status;

    // Request kinds.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage

`default_nettype wire

### rtl/slab_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slab block allocator
// Hands out and takes back blocks named by slab number and block index.
// ----------------------------------------------------------------------------
// After reset the block initializes all 1024 entries of the free-link memory
// (one entry per cycle) and takes no request until that is done; the
// configuration port works throughout. A free, or an allocate that finds no
// slab, presents its result from S_EXEC; any other allocate presents it from
// S_FIN, because it first reads the next free index from the single-port link
// memory, whose read is registered. One request is worked on at a time: the
// block returns to S_IDLE, where the next request is accepted, as its result
// enters the output register, and a result that cannot leave holds the request
// in progress until the output register is free. A new request is accepted
// while the previous result still waits in the output register.
module slab_block_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,   // blocks_in_slab
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,       // [3:0] slab_id, [9:4] block_index
    input  wire logic        s_tuser,       // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,       // [3:0] given_slab, [9:4] given_index
    output logic      [1:0]  m_tuser        // [1:0] status
);
    import sba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [6:0] r_cfg;

    logic r_func;
    logic [SLAB_W-1:0]  r_sid;
    logic [INDEX_W-1:0] r_bix;

    logic [LINK_W-1:0] r_fhead [NUM_SLABS], n_fhead [NUM_SLABS];
    logic [LINK_W-1:0] r_cnt   [NUM_SLABS], n_cnt   [NUM_SLABS];
    logic [SREF_W-1:0] r_prev  [NUM_SLABS], n_prev  [NUM_SLABS];
    logic [SREF_W-1:0] r_next  [NUM_SLABS], n_next  [NUM_SLABS];
    logic [NUM_SLABS-1:0] r_infull, n_infull;
    logic [SREF_W-1:0] r_avail, n_avail, r_full, n_full, r_rec, n_rec, r_fresh, n_fresh;

    logic r_ovalid, n_ovalid;
    t_status r_ostat, n_ostat;
    logic [SLAB_W-1:0]  r_oslab, n_oslab;
    logic [INDEX_W-1:0] r_oidx, n_oidx;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [LINK_W-1:0] ram_wdata, ram_rdata;

    logic out_free;
    logic [LINK_W-1:0] lim;
    logic [SREF_W-1:0] s_res, pn, pp;
    logic exhausted;
    logic [SLAB_W-1:0] s_a;
    logic [LINK_W-1:0] cnt_inc;

    sba_ram #(.WIDTH(LINK_W), .DEPTH(DEPTH)) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_ovalid || m_tready;
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {6'd0, r_oidx, r_oslab};
    assign m_tuser  = r_ostat;

    // Effective per-slab limit from the register.
    always_comb begin
        if (r_cfg == 7'd0) begin
            lim = LINK_W'(1);
        end else if (r_cfg > 7'(BLOCKS_MAX)) begin
            lim = LINK_W'(BLOCKS_MAX);
        end else begin
            lim = LINK_W'(r_cfg);
        end
    end

    // Slab an allocate draws from, after refilling the available list.
    always_comb begin
        exhausted = 1'b0;
        if (r_avail != SLAB_NONE) begin
            s_res = r_avail;
        end else if (r_rec != SLAB_NONE) begin
            s_res = r_rec;
        end else if (r_fresh != SLAB_NONE) begin
            s_res = r_fresh;
        end else begin
            s_res = SLAB_NONE;
            exhausted = 1'b1;
        end
        s_a = s_res[SLAB_W-1:0];
        cnt_inc = r_cnt[s_a] + LINK_W'(1);
    end

    // Request sequencer and list updates.
    always_comb begin
        n_state  = r_state;
        n_fhead  = r_fhead;
        n_cnt    = r_cnt;
        n_prev   = r_prev;
        n_next   = r_next;
        n_infull = r_infull;
        n_avail  = r_avail;
        n_full   = r_full;
        n_rec    = r_rec;
        n_fresh  = r_fresh;
        n_ovalid = r_ovalid && !m_tready;
        n_ostat  = r_ostat;
        n_oslab  = r_oslab;
        n_oidx   = r_oidx;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = {s_a, r_fhead[s_a][INDEX_W-1:0]};
        ram_wdata = r_fhead[r_sid];
        pn = SLAB_NONE;
        pp = SLAB_NONE;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = r_clr;
                ram_wdata = LINK_W'(r_clr[INDEX_W-1:0]) + LINK_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_func == FUNC_ALLOC) begin
                    if (!exhausted) begin
                        ram_re  = 1'b1;
                        n_state = S_FIN;
                    end else if (out_free) begin
                        n_ovalid = 1'b1;
                        n_ostat  = ST_NO_SLAB;
                        n_oslab  = '0;
                        n_oidx   = '0;
                        n_state  = S_IDLE;
                    end
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_oslab  = r_sid;
                    n_oidx   = r_bix;
                    n_state  = S_IDLE;
                    if (r_cnt[r_sid] == '0) begin
                        n_ostat = ST_IDLE_FREE;
                    end else begin
                        n_ostat   = ST_OK;
                        ram_we    = 1'b1;
                        ram_addr  = {r_sid, r_bix};
                        n_fhead[r_sid] = LINK_W'(r_bix);
                        n_cnt[r_sid]   = r_cnt[r_sid] - LINK_W'(1);
                        if (r_infull[r_sid]) begin
                            // Unlink from the full list, then head of recycled.
                            pp = r_prev[r_sid];
                            pn = r_next[r_sid];
                            if (pn != SLAB_NONE) n_prev[pn[SLAB_W-1:0]] = pp;
                            if (pp != SLAB_NONE) n_next[pp[SLAB_W-1:0]] = pn;
                            else n_full = pn;
                            n_prev[r_sid] = SLAB_NONE;
                            n_next[r_sid] = r_rec;
                            if (r_rec != SLAB_NONE) n_prev[r_rec[SLAB_W-1:0]] = {1'b0, r_sid};
                            n_rec = {1'b0, r_sid};
                            n_infull[r_sid] = 1'b0;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ostat  = ST_OK;
                    n_oslab  = s_a;
                    n_oidx   = r_fhead[s_a][INDEX_W-1:0];
                    n_state  = S_IDLE;
                    // Refill the available list when it is empty.
                    if (r_avail == SLAB_NONE) begin
                        if (r_rec != SLAB_NONE) begin
                            n_rec = SLAB_NONE;
                        end else begin
                            n_prev[s_a] = SLAB_NONE;
                            n_next[s_a] = SLAB_NONE;
                            n_fresh = r_fresh + SREF_W'(1);
                        end
                    end
                    n_avail  = s_res;
                    n_fhead[s_a] = ram_rdata;
                    n_cnt[s_a]   = cnt_inc;
                    if (cnt_inc >= lim || ram_rdata == LINK_NONE) begin
                        // Head of available moves to the head of full.
                        pn = (r_avail == SLAB_NONE && r_rec == SLAB_NONE)
                             ? SLAB_NONE : r_next[s_a];
                        if (pn != SLAB_NONE) n_prev[pn[SLAB_W-1:0]] = SLAB_NONE;
                        n_avail = pn;
                        n_prev[s_a] = SLAB_NONE;
                        n_next[s_a] = r_full;
                        if (r_full != SLAB_NONE) n_prev[r_full[SLAB_W-1:0]] = s_res;
                        n_full = s_res;
                        n_infull[s_a] = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cfg    <= 7'd64;
            r_ovalid <= 1'b0;
            r_infull <= '0;
            r_avail  <= '0;
            r_full   <= SLAB_NONE;
            r_rec    <= SLAB_NONE;
            r_fresh  <= SREF_W'(1);
            for (int i = 0; i < NUM_SLABS; i++) begin
                r_fhead[i] <= '0;
                r_cnt[i]   <= '0;
                r_prev[i]  <= SLAB_NONE;
                r_next[i]  <= SLAB_NONE;
            end
        end else begin
            r_state  <= n_state;
            r_clr    <= r_clr + ADDR_W'(1);
            r_ovalid <= n_ovalid;
            r_infull <= n_infull;
            r_avail  <= n_avail;
            r_full   <= n_full;
            r_rec    <= n_rec;
            r_fresh  <= n_fresh;
            r_fhead  <= n_fhead;
            r_cnt    <= n_cnt;
            r_prev   <= n_prev;
            r_next   <= n_next;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_func <= s_tuser;
            r_sid  <= s_tdata[SLAB_W-1:0];
            r_bix  <= s_tdata[SLAB_W+INDEX_W-1:SLAB_W];
        end
        r_ostat <= n_ostat;
        r_oslab <= n_oslab;
        r_oidx  <= n_oidx;
    end

endmodule

`default_nettype wire

### rtl/sba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one registered read per cycle.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slab block allocator testbench
// Drives allocate and free requests through the stream input, predicts each
// result with a behavioral copy of the slab lists, and checks every result in
// order while both sides idle in random bursts outside the last, calm phase.
// ----------------------------------------------------------------------------
module tb;
    import sba_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // Request as queued for the driver.
    typedef struct packed {
        logic       func;
        logic [3:0] slab_id;
        logic [5:0] block_index;
    } t_req;

    // Result as predicted and as observed.
    typedef struct packed {
        t_status    status;
        logic [3:0] slab;
        logic [5:0] index;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    slab_block_allocator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // Predictor state: a copy of the allocator's lists.
    logic [6:0] pr_link [NUM_SLABS*BLOCKS_MAX];
    logic [6:0] pr_head [NUM_SLABS];
    logic [6:0] pr_used [NUM_SLABS];
    logic [4:0] pr_prev [NUM_SLABS];
    logic [4:0] pr_next [NUM_SLABS];
    logic       pr_full [NUM_SLABS];
    logic [4:0] avail_head, full_head, recyc_head, fresh_cnt;
    logic [6:0] blocks_reg;

    t_req pending_reqs[$];
    t_res expected_res[$];
    int   errors = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    // Tracks what the stimulus believes is allocated, for well-formed frees.
    t_req live_blocks[$];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int slab_limit();
        if (blocks_reg == 7'd0) return 1;
        if (blocks_reg > BLOCKS_MAX) return BLOCKS_MAX;
        return int'(blocks_reg);
    endfunction

    task automatic detach_slab(input int s);
        logic [4:0] p, n;
        p = pr_prev[s];
        n = pr_next[s];
        if (n < NUM_SLABS) pr_prev[n] = p;
        if (p < NUM_SLABS) pr_next[p] = n;
        else if (pr_full[s]) full_head = n;
        else avail_head = n;
        pr_prev[s] = 5'(NUM_SLABS);
        pr_next[s] = 5'(NUM_SLABS);
        pr_full[s] = 1'b0;
    endtask

    task automatic push_front(inout logic [4:0] head, input int s);
        pr_prev[s] = 5'(NUM_SLABS);
        pr_next[s] = head;
        if (head < NUM_SLABS) pr_prev[head] = 5'(s);
        head = 5'(s);
    endtask

    task automatic predictor_reset();
        for (int s = 0; s < NUM_SLABS; s++) begin
            for (int i = 0; i < BLOCKS_MAX; i++) pr_link[s*BLOCKS_MAX+i] = 7'(i + 1);
            pr_head[s] = '0;
            pr_used[s] = '0;
            pr_prev[s] = 5'(NUM_SLABS);
            pr_next[s] = 5'(NUM_SLABS);
            pr_full[s] = 1'b0;
        end
        avail_head = '0;
        full_head = 5'(NUM_SLABS);
        recyc_head = 5'(NUM_SLABS);
        fresh_cnt = 5'd1;
        blocks_reg = 7'd64;
    endtask

    // Works out the result of one accepted request and updates the copy.
    task automatic predict_request(input t_req r);
        t_res  e;
        int    s, idx;
        e.status = ST_OK;
        if (r.func == FUNC_ALLOC) begin
            if (avail_head >= NUM_SLABS) begin
                if (recyc_head < NUM_SLABS) begin
                    avail_head = recyc_head;
                    recyc_head = 5'(NUM_SLABS);
                end else if (fresh_cnt < NUM_SLABS) begin
                    push_front(avail_head, int'(fresh_cnt));
                    fresh_cnt++;
                end else begin
                    e.status = ST_NO_SLAB;
                end
            end
            e.slab = '0;
            e.index = '0;
            if (e.status == ST_OK) begin
                s = avail_head;
                idx = pr_head[s];
                if (idx >= BLOCKS_MAX) begin
                    e.status = ST_NO_SLAB;
                end else begin
                    pr_head[s] = pr_link[s*BLOCKS_MAX+idx];
                    pr_used[s]++;
                    if (pr_used[s] >= slab_limit() || pr_head[s] >= BLOCKS_MAX) begin
                        detach_slab(s);
                        push_front(full_head, s);
                        pr_full[s] = 1'b1;
                    end
                    e.slab = 4'(s);
                    e.index = 6'(idx);
                    live_blocks.push_back('{FUNC_FREE, 4'(s), 6'(idx)});
                end
            end
        end else begin
            e.slab = r.slab_id;
            e.index = r.block_index;
            s = r.slab_id;
            if (pr_used[s] == 7'd0) begin
                e.status = ST_IDLE_FREE;
            end else begin
                idx = r.block_index;
                pr_link[s*BLOCKS_MAX+idx] = pr_head[s];
                pr_head[s] = 7'(idx);
                pr_used[s]--;
                if (pr_full[s]) begin
                    detach_slab(s);
                    push_front(recyc_head, s);
                end
            end
        end
        expected_res.push_back(e);
    endtask

    // Driver: presents queued requests, idles in random bursts unless calm.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid && s_tready) begin
                predict_request(pending_reqs.pop_front());
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    in_gap <= int'($urandom_range(0, 5));
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_reqs[0].func;
                    s_tdata <= {6'd0, pending_reqs[0].block_index, pending_reqs[0].slab_id};
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_res e;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_res.size() == 0) begin
                    $error("result with nothing expected: %h %h", m_tuser, m_tdata);
                    errors++;
                end else begin
                    e = expected_res.pop_front();
                    if (m_tuser != e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[3:0] != e.slab) begin
                        $error("given_slab expected %0d actual %0d", e.slab, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[9:4] != e.index) begin
                        $error("given_index expected %0d actual %0d", e.index,
                               m_tdata[9:4]);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_gap <= int'($urandom_range(0, 5));
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Waits until every queued request has been accepted and answered.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_tvalid || expected_res.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_blocks(input logic [6:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blocks_reg = v;
    endtask

    // One random request: mostly allocates and frees of live blocks.
    task automatic queue_random();
        t_req r;
        int   k, pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 50) begin
            r = '{FUNC_ALLOC, 4'($urandom), 6'($urandom)};
        end else if (pick < 90 && live_blocks.size() > 0) begin
            k = int'($urandom_range(0, live_blocks.size() - 1));
            r = live_blocks[k];
            live_blocks.delete(k);
        end else begin
            r = '{FUNC_FREE, 4'($urandom), 6'($urandom)};
        end
        pending_reqs.push_back(r);
    endtask

    initial begin
        logic [6:0] settings [5];
        settings = '{7'd1, 7'd3, 7'd0, 7'd127, 7'd64};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        predictor_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: free into idle slab, field extremes, allocates.
        pending_reqs.push_back('{FUNC_FREE, 4'd0, 6'd0});
        pending_reqs.push_back('{FUNC_FREE, 4'd15, 6'd63});
        for (int i = 0; i < 6; i++) pending_reqs.push_back('{FUNC_ALLOC, 4'd15, 6'd63});
        pending_reqs.push_back('{FUNC_FREE, 4'd0, 6'd63});
        pending_reqs.push_back('{FUNC_FREE, 4'd0, 6'd0});
        pending_reqs.push_back('{FUNC_FREE, 4'd0, 6'd0});
        pending_reqs.push_back('{FUNC_ALLOC, 4'd0, 6'd0});
        pending_reqs.push_back('{FUNC_ALLOC, 4'd0, 6'd0});
        drain();

        // Random phases across register settings; pool exhaustion at limit 1.
        foreach (settings[p]) begin
            set_blocks(settings[p]);
            if (p == 4) calm = 1'b1;
            for (int i = 0; i < 240; i++) queue_random();
            if (p == 0) for (int i = 0; i < 30; i++)
                pending_reqs.push_back('{FUNC_ALLOC, 4'd0, 6'd0});
            drain();
        end

        if (errors == 0 && expected_res.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
